### hdl/kwp_pkg.sv
// Shared types and constants for the keyword record stream parser.
// Used by kwp_cfg, kwp_parse and keyword_record_stream_parser_unit.
`timescale 1ns / 1ps

package kwp_pkg;

    localparam logic [31:0] HDR_MARK  = 32'd16;
    localparam logic [31:0] WORD_INTE = 32'h494E5445;
    localparam logic [31:0] WORD_REAL = 32'h5245414C;
    localparam logic [31:0] WORD_DOUB = 32'h444F5542;
    localparam logic [31:0] WORD_CHAR = 32'h43484152;
    localparam logic [31:0] WORD_LOGI = 32'h4C4F4749;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] TYPE_INTE = 3'd0;
    localparam logic [2:0] TYPE_REAL = 3'd1;
    localparam logic [2:0] TYPE_DOUB = 3'd2;
    localparam logic [2:0] TYPE_CHAR = 3'd3;
    localparam logic [2:0] TYPE_LOGI = 3'd4;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_HDR_MARK   = 3'd1;
    localparam logic [2:0] ERR_BAD_TYPE   = 3'd2;
    localparam logic [2:0] ERR_BLK_LEN    = 3'd3;
    localparam logic [2:0] ERR_BLK_TRAIL  = 3'd4;

    localparam int unsigned PADDR_W = 4;
    localparam logic REG_MATCH = 1'b0;
    localparam logic REG_SEEK  = 1'b1;

    typedef enum logic [3:0] {
        PH_LEAD      = 4'd0,
        PH_NAME_HI   = 4'd1,
        PH_NAME_LO   = 4'd2,
        PH_COUNT     = 4'd3,
        PH_TYPE      = 4'd4,
        PH_HDR_TRAIL = 4'd5,
        PH_BLK_LEAD  = 4'd6,
        PH_DATA_A    = 4'd7,
        PH_DATA_B    = 4'd8,
        PH_BLK_TRAIL = 4'd9
    } phase_t;

    typedef struct packed {
        logic        match_enable;
        logic [63:0] target_name;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] keyword_name;
        logic [30:0] value_count;
        logic [2:0]  value_type;
        logic [63:0] value;
        logic [30:0] value_index;
        logic        last;
        logic [2:0]  error_code;
    } result_t;

endpackage

### hdl/kwp_cfg.sv
// Configuration registers behind the APB-style port.
// Depends on kwp_pkg.
`timescale 1ns / 1ps

module kwp_cfg
    import kwp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic        match_enable_reg;
    logic        match_enable_next;
    logic [63:0] target_name_reg;
    logic [63:0] target_name_next;
    logic        reg_sel;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        match_enable_next = match_enable_reg;
        target_name_next  = target_name_reg;
        prdata            = 64'd0;
        unique case (reg_sel)
            REG_MATCH:
            begin
                prdata = {63'd0, match_enable_reg};
                if (wr_en)
                begin
                    match_enable_next = pwdata[0];
                end
            end
            REG_SEEK:
            begin
                prdata = target_name_reg;
                if (wr_en)
                begin
                    target_name_next = pwdata;
                end
            end
            default:
            begin
                prdata = 64'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_enable_reg <= 1'b0;
            target_name_reg  <= 64'd0;
        end
        else
        begin
            match_enable_reg <= match_enable_next;
            target_name_reg  <= target_name_next;
        end
    end

    assign cfg.match_enable = match_enable_reg;
    assign cfg.target_name  = target_name_reg;

endmodule

### hdl/kwp_parse.sv
// Record framing state and per-word decode; one word handled per step.
// Depends on kwp_pkg.
`timescale 1ns / 1ps

module kwp_parse
    import kwp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [31:0] word,
    input  cfg_t        cfg,
    output logic        res_valid,
    output result_t     res
);

    phase_t      phase_reg, phase_next;
    logic [63:0] name_reg, name_next;
    logic [30:0] count_reg, count_next;
    logic [2:0]  type_reg, type_next;
    logic [30:0] done_reg, done_next;
    logic [31:0] bytes_reg, bytes_next;
    logic [30:0] left_reg, left_next;
    logic [31:0] high_reg, high_next;
    logic        skip_reg, skip_next;
    logic        halted_reg, halted_next;

    logic        wide;
    logic        misaligned;
    logic [30:0] nvals;
    logic [30:0] remaining;
    logic        dlv_en;
    logic [63:0] dlv_val;
    logic        fail_en;
    logic [2:0]  fail_code;
    logic        is_last;

    assign wide       = (type_reg == TYPE_DOUB) || (type_reg == TYPE_CHAR);
    assign misaligned = wide ? (word[2:0] != 3'd0) : (word[1:0] != 2'd0);
    assign nvals      = wide ? {2'b00, word[31:3]} : {1'b0, word[31:2]};
    assign remaining  = count_reg - done_reg;
    assign is_last    = (({1'b0, done_reg} + 32'd1) == {1'b0, count_reg});

    always_comb
    begin
        phase_next  = phase_reg;
        name_next   = name_reg;
        count_next  = count_reg;
        type_next   = type_reg;
        done_next   = done_reg;
        bytes_next  = bytes_reg;
        left_next   = left_reg;
        high_next   = high_reg;
        skip_next   = skip_reg;
        halted_next = halted_reg;
        dlv_en      = 1'b0;
        dlv_val     = {32'd0, word};
        fail_en     = 1'b0;
        fail_code   = ERR_NONE;

        res_valid        = 1'b0;
        res.kind         = KIND_HEADER;
        res.keyword_name = name_reg;
        res.value_count  = count_reg;
        res.value_type   = type_reg;
        res.value        = 64'd0;
        res.value_index  = 31'd0;
        res.last         = 1'b0;
        res.error_code   = ERR_NONE;

        if (step && !halted_reg)
        begin
            unique case (phase_reg)
                PH_LEAD:
                begin
                    if (word != HDR_MARK)
                    begin
                        fail_en   = 1'b1;
                        fail_code = ERR_HDR_MARK;
                    end
                    else
                    begin
                        phase_next = PH_NAME_HI;
                    end
                end
                PH_NAME_HI:
                begin
                    name_next  = {word, 32'd0};
                    phase_next = PH_NAME_LO;
                end
                PH_NAME_LO:
                begin
                    name_next  = {name_reg[63:32], word};
                    phase_next = PH_COUNT;
                end
                PH_COUNT:
                begin
                    count_next = word[30:0];
                    phase_next = PH_TYPE;
                end
                PH_TYPE:
                begin
                    phase_next = PH_HDR_TRAIL;
                    case (word)
                        WORD_INTE: type_next = TYPE_INTE;
                        WORD_REAL: type_next = TYPE_REAL;
                        WORD_DOUB: type_next = TYPE_DOUB;
                        WORD_CHAR: type_next = TYPE_CHAR;
                        WORD_LOGI: type_next = TYPE_LOGI;
                        default:
                        begin
                            phase_next = phase_reg;
                            fail_en    = 1'b1;
                            fail_code  = ERR_BAD_TYPE;
                        end
                    endcase
                end
                PH_HDR_TRAIL:
                begin
                    if (word != HDR_MARK)
                    begin
                        fail_en   = 1'b1;
                        fail_code = ERR_HDR_MARK;
                    end
                    else
                    begin
                        skip_next  = cfg.match_enable && (name_reg != cfg.target_name);
                        done_next  = 31'd0;
                        phase_next = (count_reg == 31'd0) ? PH_LEAD : PH_BLK_LEAD;
                        res_valid  = !skip_next;
                        res.kind   = KIND_HEADER;
                    end
                end
                PH_BLK_LEAD:
                begin
                    if (misaligned || (nvals > remaining))
                    begin
                        fail_en   = 1'b1;
                        fail_code = ERR_BLK_LEN;
                    end
                    else
                    begin
                        bytes_next = word;
                        left_next  = nvals;
                        phase_next = (nvals == 31'd0) ? PH_BLK_TRAIL : PH_DATA_A;
                    end
                end
                PH_DATA_A:
                begin
                    if (wide)
                    begin
                        high_next  = word;
                        phase_next = PH_DATA_B;
                    end
                    else
                    begin
                        dlv_en  = 1'b1;
                        dlv_val = {32'd0, word};
                    end
                end
                PH_DATA_B:
                begin
                    dlv_en  = 1'b1;
                    dlv_val = {high_reg, word};
                end
                PH_BLK_TRAIL:
                begin
                    if (word != bytes_reg)
                    begin
                        fail_en   = 1'b1;
                        fail_code = ERR_BLK_TRAIL;
                    end
                    else
                    begin
                        phase_next = (done_reg >= count_reg) ? PH_LEAD : PH_BLK_LEAD;
                    end
                end
                default:
                begin
                    phase_next = PH_LEAD;
                end
            endcase

            if (dlv_en)
            begin
                res_valid       = !skip_reg;
                res.kind        = KIND_DATA;
                res.value       = dlv_val;
                res.value_index = done_reg;
                res.last        = is_last;
                done_next       = done_reg + 31'd1;
                left_next       = left_reg - 31'd1;
                phase_next      = (left_reg == 31'd1) ? PH_BLK_TRAIL : PH_DATA_A;
            end

            if (fail_en)
            begin
                halted_next    = 1'b1;
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = fail_code;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEAD;
            name_reg   <= 64'd0;
            count_reg  <= 31'd0;
            type_reg   <= TYPE_INTE;
            done_reg   <= 31'd0;
            bytes_reg  <= 32'd0;
            left_reg   <= 31'd0;
            high_reg   <= 32'd0;
            skip_reg   <= 1'b0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            name_reg   <= name_next;
            count_reg  <= count_next;
            type_reg   <= type_next;
            done_reg   <= done_next;
            bytes_reg  <= bytes_next;
            left_reg   <= left_next;
            high_reg   <= high_next;
            skip_reg   <= skip_next;
            halted_reg <= halted_next;
        end
    end

endmodule

### hdl/keyword_record_stream_parser_unit.sv
// Keyword record stream parser: top level with input and result registers.
// Depends on kwp_pkg, kwp_cfg and kwp_parse.
//
// Usage:
//   Input channel: one 32-bit stream word per transfer (in_valid/in_stall).
//   Output channel: header, data value or error results (out_valid/out_stall).
//   A word is taken when in_valid is high and in_stall is low; a result
//   is taken when out_valid is high and out_stall is low.
//   Each word is held in the input register; the parse step then loads its
//   result, if any, into the result register.
//   Throughput: one word per cycle while the receiver does not stall; the parse
//   step is a single pass from the input register to the result register.
//   Words that produce no result (markers, name, count, type, high halves,
//   skipped keywords) still pass through the input register and the parse step.
//   When the receiver stalls, the result register holds and one more word is
//   buffered in the input register; after that in_stall rises.
//   After the first framing or type error one error result is sent and all
//   later words are swallowed until reset.
//   Reset clears the valid flags of both registers and returns the parser to
//   waiting for a header lead marker; match_enable and target_name reset to zero.
//   Registers: match_enable at byte address 0, target_name at byte address 8.
`timescale 1ns / 1ps

module keyword_record_stream_parser_unit
    import kwp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        word,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic [63:0]        keyword_name,
    output logic [30:0]        value_count,
    output logic [2:0]         value_type,
    output logic [63:0]        value,
    output logic [30:0]        value_index,
    output logic               last,
    output logic [2:0]         error_code
);

    cfg_t        cfg;
    logic        in_valid_reg, in_valid_next;
    logic [31:0] word_reg, word_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;
    logic        advance;
    logic        step;
    logic        res_valid;
    result_t     res;

    kwp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kwp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .word      (word_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        word_next      = word_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            in_valid_next  = 1'b0;
            out_valid_next = step && res_valid;
            if (step)
            begin
                out_next = res;
            end
        end
        if (in_valid && !in_stall)
        begin
            in_valid_next = 1'b1;
            word_next     = word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        out_reg  <= out_next;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_reg.kind;
    assign keyword_name = out_reg.keyword_name;
    assign value_count  = out_reg.value_count;
    assign value_type   = out_reg.value_type;
    assign value        = out_reg.value;
    assign value_index  = out_reg.value_index;
    assign last         = out_reg.last;
    assign error_code   = out_reg.error_code;

`ifndef SYNTHESIS
    a_err_code_on_error_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
        else $error("error code does not match result kind");

    a_last_is_final_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |->
            (kind == KIND_DATA) && (({1'b0, value_index} + 32'd1) == {1'b0, value_count}))
        else $error("last flag on a value that is not the final one");

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while result side is free");

    a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && (kind == KIND_ERROR)) |=> !out_valid)
        else $error("result produced after an error");
`endif

endmodule

### tb/keyword_record_stream_parser_unit_test.sv
// Self-checking testbench for keyword_record_stream_parser_unit: streams keyword records
// through the word channel, predicts every header, value and error result, and checks them.
// Depends on kwp_pkg and the keyword_record_stream_parser_unit RTL.
`timescale 1ns / 1ps

module keyword_record_stream_parser_unit_test;
    import kwp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [PADDR_W-1:0] ADDR_MATCH = {REG_MATCH, 3'b000};
    localparam logic [PADDR_W-1:0] ADDR_SEEK  = {REG_SEEK, 3'b000};

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [31:0]        word;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         kind;
    logic [63:0]        keyword_name;
    logic [30:0]        value_count;
    logic [2:0]         value_type;
    logic [63:0]        value;
    logic [30:0]        value_index;
    logic               last;
    logic [2:0]         error_code;

    keyword_record_stream_parser_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .word         (word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .keyword_name (keyword_name),
        .value_count  (value_count),
        .value_type   (value_type),
        .value        (value),
        .value_index  (value_index),
        .last         (last),
        .error_code   (error_code)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // parser shadow state
    phase_t      ph;
    logic [63:0] cur_name;
    logic [30:0] decl_count;
    logic [30:0] done_count;
    logic [30:0] blk_left;
    logic [2:0]  cur_type;
    logic [31:0] blk_bytes;
    logic [31:0] high_word;
    logic        skip_kw;
    logic        halted;
    cfg_t        filter;

    result_t expected_results[$];

    int    fails = 0;
    int    cycles = 0;
    int    words_sent = 0;
    int    headers_seen = 0;
    int    values_seen = 0;
    int    errors_seen = 0;
    int    gap_pct = 0;
    int    stall_pct = 0;
    int    halt_case = 0;
    string halt_names[6] = '{"bad lead marker", "bad header trailer", "unknown type",
                             "ragged block length", "oversized block", "block trailer mismatch"};

    function automatic result_t make_result(input logic [1:0] k, input logic [63:0] v,
                                            input logic [30:0] idx, input logic lst,
                                            input logic [2:0] err);
        result_t r;
        r.kind         = k;
        r.keyword_name = cur_name;
        r.value_count  = decl_count;
        r.value_type   = cur_type;
        r.value        = v;
        r.value_index  = idx;
        r.last         = lst;
        r.error_code   = err;
        return r;
    endfunction

    function automatic result_t halt_with(input logic [2:0] code);
        halted = 1'b1;
        return make_result(KIND_ERROR, 64'd0, 31'd0, 1'b0, code);
    endfunction

    function automatic bit deliver_value(input logic [63:0] v, output result_t r);
        bit emit;
        r = '0;
        emit = !skip_kw;
        if (emit)
            r = make_result(KIND_DATA, v, done_count,
                            ({1'b0, done_count} + 32'd1) == {1'b0, decl_count}, ERR_NONE);
        done_count = done_count + 31'd1;
        blk_left = blk_left - 31'd1;
        ph = (blk_left == 31'd0) ? PH_BLK_TRAIL : PH_DATA_A;
        return emit;
    endfunction

    function automatic bit parse_word(input logic [31:0] w, output result_t r);
        logic [31:0] vsize;
        logic [31:0] nvals;
        logic [31:0] remaining;
        bit          wide;
        r = '0;
        if (halted)
            return 0;
        wide = (cur_type == TYPE_DOUB) || (cur_type == TYPE_CHAR);
        vsize = wide ? 32'd8 : 32'd4;
        case (ph)
            PH_LEAD:
            begin
                if (w != HDR_MARK)
                begin
                    r = halt_with(ERR_HDR_MARK);
                    return 1;
                end
                ph = PH_NAME_HI;
            end
            PH_NAME_HI:
            begin
                cur_name = {w, 32'd0};
                ph = PH_NAME_LO;
            end
            PH_NAME_LO:
            begin
                cur_name[31:0] = w;
                ph = PH_COUNT;
            end
            PH_COUNT:
            begin
                decl_count = w[30:0];
                ph = PH_TYPE;
            end
            PH_TYPE:
            begin
                case (w)
                    WORD_INTE: cur_type = TYPE_INTE;
                    WORD_REAL: cur_type = TYPE_REAL;
                    WORD_DOUB: cur_type = TYPE_DOUB;
                    WORD_CHAR: cur_type = TYPE_CHAR;
                    WORD_LOGI: cur_type = TYPE_LOGI;
                    default:
                    begin
                        r = halt_with(ERR_BAD_TYPE);
                        return 1;
                    end
                endcase
                ph = PH_HDR_TRAIL;
            end
            PH_HDR_TRAIL:
            begin
                if (w != HDR_MARK)
                begin
                    r = halt_with(ERR_HDR_MARK);
                    return 1;
                end
                skip_kw = filter.match_enable && (cur_name != filter.target_name);
                done_count = 31'd0;
                ph = (decl_count == 31'd0) ? PH_LEAD : PH_BLK_LEAD;
                if (!skip_kw)
                begin
                    r = make_result(KIND_HEADER, 64'd0, 31'd0, 1'b0, ERR_NONE);
                    return 1;
                end
            end
            PH_BLK_LEAD:
            begin
                nvals = w / vsize;
                remaining = {1'b0, decl_count} - {1'b0, done_count};
                if ((w % vsize) != 32'd0 || nvals > remaining)
                begin
                    r = halt_with(ERR_BLK_LEN);
                    return 1;
                end
                blk_bytes = w;
                blk_left = nvals[30:0];
                ph = (nvals == 32'd0) ? PH_BLK_TRAIL : PH_DATA_A;
            end
            PH_DATA_A:
            begin
                if (!wide)
                    return deliver_value({32'd0, w}, r);
                high_word = w;
                ph = PH_DATA_B;
            end
            PH_DATA_B:
                return deliver_value({high_word, w}, r);
            PH_BLK_TRAIL:
            begin
                if (w != blk_bytes)
                begin
                    r = halt_with(ERR_BLK_TRAIL);
                    return 1;
                end
                ph = ({1'b0, done_count} >= {1'b0, decl_count}) ? PH_LEAD : PH_BLK_LEAD;
            end
            default:
                ph = PH_LEAD;
        endcase
        return 0;
    endfunction

    function automatic logic [31:0] type_word(input logic [2:0] t);
        case (t)
            TYPE_INTE: return WORD_INTE;
            TYPE_REAL: return WORD_REAL;
            TYPE_DOUB: return WORD_DOUB;
            TYPE_CHAR: return WORD_CHAR;
            default:   return WORD_LOGI;
        endcase
    endfunction

    function automatic logic [31:0] data_word();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", fname, want, got);
            fails++;
        end
    endtask

    task automatic send_word(input logic [31:0] w);
        result_t r;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        word <= w;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
        if (parse_word(w, r))
            expected_results.push_back(r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [63:0] d);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_check(input string fname, input logic [PADDR_W-1:0] a,
                             input logic [63:0] mask, input logic [63:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= a;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        check_field(fname, want, prdata & mask);
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_filter(input logic me, input logic [63:0] seek);
        drain();
        apb_write(ADDR_MATCH, {63'd0, me});
        apb_write(ADDR_SEEK, seek);
        filter.match_enable = me;
        filter.target_name = seek;
        apb_check("match_enable readback", ADDR_MATCH, 64'd1, {63'd0, me});
        apb_check("target_name readback", ADDR_SEEK, '1, seek);
    endtask

    task automatic send_header(input logic [63:0] name, input logic [31:0] count_word,
                               input logic [31:0] tword, input logic [31:0] trail);
        send_word(HDR_MARK);
        send_word(name[63:32]);
        send_word(name[31:0]);
        send_word(count_word);
        send_word(tword);
        send_word(trail);
    endtask

    task automatic send_keyword();
        logic [63:0] name;
        logic [31:0] count_word;
        logic [31:0] bytes;
        logic [2:0]  vtype;
        int          left;
        int          n;
        bit          wide;
        case ($urandom_range(0, 5))
            0, 1:    name = filter.target_name;
            2:       name = '0;
            3:       name = '1;
            default: name = {$urandom, $urandom};
        endcase
        left = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
        count_word = {1'($urandom_range(0, 1)), 31'(left)};
        vtype = 3'($urandom_range(0, 4));
        wide = (vtype == TYPE_DOUB) || (vtype == TYPE_CHAR);
        send_header(name, count_word, type_word(vtype), HDR_MARK);
        while (left > 0)
        begin
            n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, left);
            bytes = 32'(n) * (wide ? 32'd8 : 32'd4);
            send_word(bytes);
            repeat (wide ? 2 * n : n) send_word(data_word());
            send_word(bytes);
            left -= n;
        end
    endtask

    task automatic run_keywords(input int n_words);
        int start;
        start = words_sent;
        while (words_sent - start < n_words)
            send_keyword();
    endtask

    task automatic test_directed_records();
        logic [31:0] seq[$];
        gap_pct = 21;
        stall_pct = 77;
        set_filter(1'b0, '0);
        seq = '{HDR_MARK, 32'h5354_4152, 32'h5420_2020, 32'h8000_0000, WORD_INTE, HDR_MARK,
                HDR_MARK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, WORD_DOUB, HDR_MARK,
                32'd0, 32'd0, 32'd8, 32'hFFFF_FFFF, 32'h0000_0000, 32'd8,
                HDR_MARK, 32'd0, 32'd0, 32'd1, WORD_LOGI, HDR_MARK,
                32'd4, 32'hFFFF_FFFF, 32'd4};
        foreach (seq[i])
            send_word(seq[i]);
    endtask

    task automatic test_all_keywords();
        gap_pct = 21;
        stall_pct = 77;
        set_filter(1'b0, {$urandom, $urandom});
        run_keywords(650);
    endtask

    task automatic test_name_filter();
        gap_pct = 77;
        stall_pct = 21;
        set_filter(1'b1, {$urandom, $urandom});
        run_keywords(325);
        set_filter(1'b1, '1);
        run_keywords(325);
    endtask

    task automatic test_full_rate();
        gap_pct = 0;
        stall_pct = 0;
        set_filter(1'b1, '0);
        run_keywords(325);
        set_filter(1'b0, '1);
        run_keywords(325);
    endtask

    task automatic test_halt_on_error();
        logic [63:0] name;
        logic [31:0] size;
        logic [31:0] bytes;
        logic [31:0] huge_count;
        logic [31:0] flip;
        logic [2:0]  vtype;
        int          n;
        halt_case = $urandom_range(0, 5);
        name = {$urandom, $urandom};
        vtype = 3'($urandom_range(0, 4));
        size = (vtype == TYPE_DOUB || vtype == TYPE_CHAR) ? 32'd8 : 32'd4;
        flip = 32'd1 << $urandom_range(0, 31);
        huge_count = {1'($urandom_range(0, 1)), 1'b1, 30'($urandom)};
        n = $urandom_range(1, 3);
        case (halt_case)
            0: send_word(HDR_MARK ^ flip);
            1: send_header(name, 32'd3, type_word(vtype), HDR_MARK ^ flip);
            2: send_header(name, 32'd3, WORD_INTE ^ flip, HDR_MARK);
            3:
            begin
                send_header(name, huge_count, type_word(vtype), HDR_MARK);
                send_word(size * $urandom_range(0, 1000) + $urandom_range(1, size - 1));
            end
            4:
            begin
                send_header(name, 32'(n), type_word(vtype), HDR_MARK);
                send_word($urandom_range(0, 1) ? 32'hFFFF_FFF8
                                               : size * 32'(n + $urandom_range(1, 4)));
            end
            default:
            begin
                send_header(name, huge_count, type_word(vtype), HDR_MARK);
                bytes = 32'(n) * size;
                send_word(bytes);
                repeat (bytes / 4) send_word(data_word());
                send_word(bytes ^ flip);
            end
        endcase
        repeat (12) send_word($urandom);
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: kind %0d, error_code %0d", kind, error_code);
                fails++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("kind", 64'(want.kind), 64'(kind));
                check_field("keyword_name", want.keyword_name, keyword_name);
                check_field("value_count", 64'(want.value_count), 64'(value_count));
                check_field("value_type", 64'(want.value_type), 64'(value_type));
                check_field("value", want.value, value);
                check_field("value_index", 64'(want.value_index), 64'(value_index));
                check_field("last", 64'(want.last), 64'(last));
                check_field("error_code", 64'(want.error_code), 64'(error_code));
                case (kind)
                    KIND_HEADER: headers_seen++;
                    KIND_DATA:   values_seen++;
                    default:     errors_seen++;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        ph = PH_LEAD;
        cur_name = '0;
        decl_count = '0;
        done_count = '0;
        blk_left = '0;
        cur_type = '0;
        blk_bytes = '0;
        high_word = '0;
        skip_kw = 1'b0;
        halted = 1'b0;
        filter = '0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        word <= '0;
        out_stall <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_records();
        test_all_keywords();
        test_name_filter();
        test_full_rate();
        test_halt_on_error();

        drain();
        repeat (12) @(posedge clk);
        $display("streamed %0d words: %0d headers, %0d values, %0d errors checked",
                 words_sent, headers_seen, values_seen, errors_seen);
        $display("filter on and off with target names at both extremes; halt via %s",
                 halt_names[halt_case]);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### keyword_record_stream_parser_unit.f
hdl/kwp_pkg.sv
hdl/kwp_cfg.sv
hdl/kwp_parse.sv
hdl/keyword_record_stream_parser_unit.sv
tb/keyword_record_stream_parser_unit_test.sv
